// File: hdl/lru_pft_pkg.sv
// ----------------------------------------------------------------------------
// LRU page frame table package
// Shared widths, outcome codes and command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package lru_pft_pkg;
    localparam int FRAMES_DEFAULT   = 16;
    localparam int PID_W            = 16;
    localparam int ADDR_W           = 32;
    localparam int STAMP_W          = 32;
    localparam logic [31:0] PAGE_SIZE_RESET = 32'd4096;

    localparam logic [1:0] OUT_HIT     = 2'd0;
    localparam logic [1:0] OUT_FILL    = 2'd1;
    localparam logic [1:0] OUT_REPLACE = 2'd2;
    localparam logic [1:0] OUT_REMOVE  = 2'd3;

    typedef struct packed {
        logic load;       // capture request, start divide
        logic div_step;   // one quotient bit
        logic scan_clr;   // reset scan index and flags
        logic scan_step;  // examine one frame
        logic commit;     // write table, build result
    } ctl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic is_remove;
    } ctl_sts_t;
endpackage
`default_nettype wire

// File: hdl/lru_page_frame_table_core.sv
// ----------------------------------------------------------------------------
// LRU page frame table core
// Fully associative frame table with LRU replacement and process removal.
// ----------------------------------------------------------------------------
// Sequence: an access is divided, the frames are scanned, then the table is
// committed and the result is registered; a removal skips the divide.
// Handoff: one request at a time; the next is accepted the cycle after the
// result is taken.
// Reset: asynchronous; all frames empty, stamps zero, next stamp 1.
`default_nettype none
module lru_page_frame_table_core
    import lru_pft_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // pid[15:0], address[47:16]
    input  wire logic        s_tuser,  // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata   // outcome, frame, victim_pid, victim_page,
                                       // freed_count, zero fill
);
    ctl_cmd_t cmd;
    ctl_sts_t sts;
    logic [1:0]  outcome;
    logic [3:0]  frame;
    logic [15:0] vpid;
    logic [31:0] vpage;
    logic [4:0]  freed;

    lru_pft_ctrl u_ctrl (
        .clk (clk), .rst_n (rst_n),
        .in_valid (s_tvalid), .in_ready (s_tready),
        .out_valid (m_tvalid), .out_ready (m_tready),
        .sts (sts), .cmd (cmd)
    );

    lru_pft_dp #(.FRAMES(FRAMES)) u_dp (
        .clk (clk), .rst_n (rst_n),
        .cfg_we (cfg_we), .cfg_data (cfg_data),
        .in_kind (s_tuser), .in_pid (s_tdata[15:0]), .in_addr (s_tdata[47:16]),
        .cmd (cmd), .sts (sts),
        .res_outcome (outcome), .res_frame (frame), .res_vpid (vpid),
        .res_vpage (vpage), .res_freed (freed)
    );

    assign m_tdata = {5'd0, freed, vpage, vpid, frame, outcome};
endmodule
`default_nettype wire

// File: hdl/lru_pft_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_pft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/lru_pft_ctrl.sv
// ----------------------------------------------------------------------------
// LRU page frame table controller
// Sequences divide, frame scan, commit and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_pft_ctrl
    import lru_pft_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_COMM = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done || sts.is_remove)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_COMM;
                end
            end
            S_COMM:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/lru_pft_dp.sv
// ----------------------------------------------------------------------------
// LRU page frame table datapath
// Restoring divider, frame tables, serial scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_pft_dp
    import lru_pft_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_data,
    input  wire logic              in_kind,
    input  wire logic [PID_W-1:0]  in_pid,
    input  wire logic [ADDR_W-1:0] in_addr,
    input  wire ctl_cmd_t          cmd,
    output ctl_sts_t               sts,
    output logic [1:0]             res_outcome,
    output logic [3:0]             res_frame,
    output logic [PID_W-1:0]       res_vpid,
    output logic [31:0]            res_vpage,
    output logic [4:0]             res_freed
);
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    logic [31:0]        page_size_reg;
    logic [STAMP_W-1:0] next_stamp_reg;
    logic               kind_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [31:0]        quo_reg, div_reg;
    logic [32:0]        rem_reg;
    logic [5:0]         dcnt_reg;

    logic [PID_W-1:0]   owner_reg [FRAMES];
    logic [STAMP_W-1:0] stamp_reg [FRAMES];

    logic [IW:0]        idx_reg;
    logic [IW-1:0]      prev_reg;
    logic               pvalid_reg;
    logic               hit_reg, free_reg;
    logic [IW-1:0]      hit_idx_reg, free_idx_reg, min_idx_reg;
    logic [STAMP_W-1:0] min_stamp_reg;
    logic [CW-1:0]      freed_reg;

    logic [31:0]        page_rd;
    logic               page_we;
    logic [IW-1:0]      page_waddr;
    logic [IW-1:0]      vic_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg <= PAGE_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            page_size_reg <= cfg_data;
        end
    end

    // restoring divide, one quotient bit per cycle
    logic [32:0] rem_sh;
    assign rem_sh = {rem_reg[31:0], quo_reg[31]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            pid_reg  <= in_pid;
            quo_reg  <= in_addr;
            rem_reg  <= '0;
            div_reg  <= (page_size_reg == 32'd0) ? 32'd1 : page_size_reg;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, div_reg})
            begin
                rem_reg <= rem_sh - {1'b0, div_reg};
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 6'd1;
        end
    end

    // page RAM read data is registered, so it belongs to the previous scan index;
    // once the scan is done it reads the victim frame so its page is ready at commit
    lru_pft_ram #(.WIDTH(32), .DEPTH(FRAMES)) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (quo_reg),
        .raddr (sts.scan_done ? vic_idx : idx_reg[IW-1:0]),
        .rdata (page_rd)
    );

    assign vic_idx    = free_reg ? free_idx_reg : min_idx_reg;
    assign page_we    = cmd.commit && !kind_reg && !hit_reg;
    assign page_waddr = vic_idx;

    logic scan_end;
    assign scan_end = (idx_reg == (IW+1)'(FRAMES));

    always_ff @(posedge clk)
    begin
        if (cmd.scan_clr)
        begin
            idx_reg    <= '0;
            pvalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
            freed_reg  <= '0;
            min_idx_reg   <= '0;
            min_stamp_reg <= stamp_reg[0];
        end
        else if (cmd.scan_step)
        begin
            pvalid_reg <= !scan_end;
            prev_reg   <= idx_reg[IW-1:0];
            if (!scan_end)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (owner_reg[idx_reg[IW-1:0]] == 16'd0 && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= idx_reg[IW-1:0];
                end
                if (stamp_reg[idx_reg[IW-1:0]] < min_stamp_reg)
                begin
                    min_stamp_reg <= stamp_reg[idx_reg[IW-1:0]];
                    min_idx_reg   <= idx_reg[IW-1:0];
                end
                if (owner_reg[idx_reg[IW-1:0]] == pid_reg && pid_reg != 16'd0)
                begin
                    freed_reg <= freed_reg + 1'b1;
                end
            end
            if (pvalid_reg && !hit_reg && owner_reg[prev_reg] != 16'd0
                && owner_reg[prev_reg] == pid_reg && page_rd == quo_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= prev_reg;
            end
        end
    end

    assign sts.div_done  = (dcnt_reg == 6'd32);
    assign sts.is_remove = kind_reg;
    assign sts.scan_done = scan_end && !pvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_stamp_reg <= 32'd1;
            for (int i = 0; i < FRAMES; i++)
            begin
                owner_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (kind_reg)
            begin
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (owner_reg[i] == pid_reg)
                    begin
                        owner_reg[i] <= '0;
                        stamp_reg[i] <= '0;
                    end
                end
            end
            else
            begin
                next_stamp_reg <= next_stamp_reg + 32'd1;
                if (hit_reg)
                begin
                    stamp_reg[hit_idx_reg] <= next_stamp_reg;
                end
                else
                begin
                    owner_reg[vic_idx] <= pid_reg;
                    stamp_reg[vic_idx] <= next_stamp_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_vpid  <= '0;
            res_vpage <= '0;
            res_freed <= '0;
            res_frame <= '0;
            if (kind_reg)
            begin
                res_outcome <= OUT_REMOVE;
                res_freed   <= 5'(freed_reg);
            end
            else if (hit_reg)
            begin
                res_outcome <= OUT_HIT;
                res_frame   <= 4'(hit_idx_reg);
            end
            else if (free_reg)
            begin
                res_outcome <= OUT_FILL;
                res_frame   <= 4'(free_idx_reg);
            end
            else
            begin
                res_outcome <= OUT_REPLACE;
                res_frame   <= 4'(min_idx_reg);
                res_vpid    <= owner_reg[min_idx_reg];
                res_vpage   <= page_rd;
            end
        end
    end
endmodule
`default_nettype wire

// File: hdl/lru_pft_checker.sv
// ----------------------------------------------------------------------------
// LRU page frame table checker
// Port-level properties of the core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_pft_checker
    import lru_pft_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);
    // one request in flight
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_remove_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == OUT_REMOVE |-> m_tdata[53:2] == '0)
        else $error("removal fields");
    a_nonrepl_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == OUT_HIT || m_tdata[1:0] == OUT_FILL)
        |-> m_tdata[58:6] == '0) else $error("non-replace fields");
    a_accept_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule

bind lru_page_frame_table_core lru_pft_checker u_checker (
    .clk (clk), .rst_n (rst_n),
    .s_tvalid (s_tvalid), .s_tready (s_tready),
    .m_tvalid (m_tvalid), .m_tready (m_tready), .m_tdata (m_tdata)
);
`default_nettype wire
